/* rtl/tgam_pkg.sv */
// Shared types and codes for the touch gesture action mapper.
// Depends on nothing; tgam_req_if and the mapper import it.
package tgam_pkg;

   localparam int CoordWidth = 16;
   localparam int ArgWidth   = 32;
   localparam int ProdWidth  = 39;
   localparam int DistWidth  = 17;
   localparam int StepWidth  = 16;
   localparam int CsrIdxWidth = 2;

   typedef enum logic [2:0] {
      EV_BEGIN  = 3'd0,
      EV_END    = 3'd1,
      EV_PAN    = 3'd2,
      EV_TAP    = 3'd3,
      EV_ZOOM   = 3'd4,
      EV_SCROLL = 3'd5,
      EV_OTHER  = 3'd6
   } event_type;

   typedef enum logic [3:0] {
      ACT_BACK_SHORT  = 4'd0,
      ACT_BACK_MEDIUM = 4'd1,
      ACT_FWD_SHORT   = 4'd2,
      ACT_FWD_MEDIUM  = 4'd3,
      ACT_VOL_UP      = 4'd4,
      ACT_VOL_DOWN    = 4'd5,
      ACT_PLAY_PAUSE  = 4'd6,
      ACT_FULLSCREEN  = 4'd7,
      ACT_LEAVE_FULL  = 4'd8,
      ACT_FOV_IN      = 4'd9,
      ACT_FOV_OUT     = 4'd10
   } action_type;

   typedef enum logic [1:0] {
      PAN_UNDEF  = 2'd0,
      PAN_JUMP   = 2'd1,
      PAN_VOLUME = 2'd2,
      PAN_BRIGHT = 2'd3
   } pan_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_PROJECTED_MODE    = 2'd0,
      CSR_CLASSIFY_DISTANCE = 2'd1,
      CSR_VOLUME_STEP       = 2'd2,
      CSR_UNUSED            = 2'd3
   } csr_index_type;

   localparam logic [2:0] FlagBegin    = 3'd1;
   localparam logic [2:0] FlagEnd      = 3'd4;
   localparam logic [DistWidth-1:0] ClassifyReset = 17'd50;
   localparam logic [StepWidth-1:0] VolumeReset   = 16'd100;

endpackage

/* rtl/tgam_req_if.sv */
// Request channel carrying one gesture event per beat.
// Depends on tgam_pkg for field widths.
interface tgam_req_if
   import tgam_pkg::*;
();
   logic                         valid;
   logic                         ready;
   logic [2:0]                   req_type;
   logic [2:0]                   gesture_flags;
   logic signed [CoordWidth-1:0] pos_x;
   logic signed [CoordWidth-1:0] pos_y;
   logic [ArgWidth-1:0]          gesture_arg;

   modport source (output valid, req_type, gesture_flags, pos_x, pos_y, gesture_arg,
                   input ready);
   modport sink   (input valid, req_type, gesture_flags, pos_x, pos_y, gesture_arg,
                   output ready);
endinterface

/* rtl/tgam_rsp_if.sv */
// Response channel carrying one handled flag and optional action code per beat.
// Depends on nothing beyond plain logic types.
interface tgam_rsp_if;
   logic       valid;
   logic       ready;
   logic       handled;
   logic       action_valid;
   logic [3:0] action_code;

   modport source (output valid, handled, action_valid, action_code, input ready);
   modport sink   (input valid, handled, action_valid, action_code, output ready);
endinterface

/* rtl/touch_gesture_action_mapper.sv */
// Touch gesture action mapper: turns gesture events into handled flags and actions.
// Depends on tgam_pkg, tgam_req_if and tgam_rsp_if.
//
//   channel   direction  contents
//   req_if    in         req_type, gesture_flags, pos_x, pos_y, gesture_arg
//   rsp_if    out        handled, action_valid, action_code
//   csr_*     in         write enable, register index, write data
//
// Every request beat yields one response beat after acceptance: it passes through the input
// register, where the zoom products are held, and then through the result register.
// A new beat is accepted every cycle unless the result register is full and not taken.
// Reset is synchronous and restores all gesture state and configuration registers.
module touch_gesture_action_mapper
   import tgam_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   tgam_req_if.sink               req_if,
   tgam_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [DistWidth-1:0]   csr_wdata
);

   logic                         mode_ff;
   logic [DistWidth-1:0]         classify_ff;
   logic [StepWidth-1:0]         step_ff;

   logic                         s_vld_ff;
   logic [2:0]                   s_type_ff;
   logic [2:0]                   s_flags_ff;
   logic signed [CoordWidth-1:0] s_x_ff;
   logic signed [CoordWidth-1:0] s_y_ff;
   logic [ArgWidth-1:0]          s_arg_ff;
   logic [ProdWidth-1:0]         s_arg100_ff;
   logic [ProdWidth-1:0]         s_arg101_ff;
   logic [ProdWidth-1:0]         s_arg99_ff;

   logic signed [CoordWidth-1:0] start_x_ff, start_x_in;
   logic signed [CoordWidth-1:0] start_y_ff, start_y_in;
   logic signed [CoordWidth-1:0] last_y_ff, last_y_in;
   logic                         two_ff, two_in;
   pan_type                      pan_ff, pan_in;
   logic                         seen_ff, seen_in;
   logic [ArgWidth-1:0]          zoom_start_ff, zoom_start_in;
   logic [ProdWidth-1:0]         zl101_ff, zl101_in;
   logic [ProdWidth-1:0]         zl99_ff, zl99_in;

   logic                         rsp_vld_ff;
   logic                         handled_ff, handled_in;
   logic                         act_vld_ff, act_vld_in;
   logic [3:0]                   act_code_ff;
   action_type                   act_code_in;

   logic                         advance;
   logic signed [CoordWidth-1:0] pan_sx, pan_sy;
   logic signed [DistWidth-1:0]  dx, dy;
   logic [DistWidth-1:0]         ax, ay;
   logic [DistWidth:0]           travel;
   logic                         pan_two;
   pan_type                      pan_new;
   logic signed [DistWidth:0]    off;
   logic signed [DistWidth:0]    step_s;
   logic                         back;

   assign advance      = s_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !s_vld_ff || advance;

   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.handled      = handled_ff;
   assign rsp_if.action_valid = act_vld_ff;
   assign rsp_if.action_code  = act_code_ff;

   // Pan geometry, taken against the start point as updated by this beat.
   always_comb begin
      pan_sx  = s_flags_ff[0] ? s_x_ff : start_x_ff;
      pan_sy  = s_flags_ff[0] ? s_y_ff : start_y_ff;
      pan_two = two_ff || (s_arg_ff != '0);
      dx      = DistWidth'(pan_sx) - DistWidth'(s_x_ff);
      dy      = DistWidth'(pan_sy) - DistWidth'(s_y_ff);
      ax      = dx[DistWidth-1] ? DistWidth'(-dx) : DistWidth'(dx);
      ay      = dy[DistWidth-1] ? DistWidth'(-dy) : DistWidth'(dy);
      travel  = {1'b0, ax} + {1'b0, ay};
      pan_new = pan_ff;
      if (pan_ff == PAN_UNDEF && (!mode_ff || pan_two) && travel > {1'b0, classify_ff}) begin
         if (ax > ay) begin
            pan_new = PAN_JUMP;
         end else if (pan_two && !mode_ff) begin
            pan_new = PAN_BRIGHT;
         end else begin
            pan_new = PAN_VOLUME;
         end
      end
      off    = (DistWidth + 1)'(last_y_ff) - (DistWidth + 1)'(s_y_ff);
      step_s = $signed({2'b00, step_ff});
      back   = start_x_ff > s_x_ff;
   end

   always_comb begin
      start_x_in    = start_x_ff;
      start_y_in    = start_y_ff;
      last_y_in     = last_y_ff;
      two_in        = two_ff;
      pan_in        = pan_ff;
      seen_in       = seen_ff;
      zoom_start_in = zoom_start_ff;
      zl101_in      = zl101_ff;
      zl99_in       = zl99_ff;
      handled_in    = 1'b0;
      act_vld_in    = 1'b0;
      act_code_in   = ACT_BACK_SHORT;
      unique case (s_type_ff)
         EV_BEGIN: begin
            start_x_in = s_x_ff;
            start_y_in = s_y_ff;
            last_y_in  = s_y_ff;
            two_in     = 1'b0;
         end
         EV_END: begin
            if (seen_ff && pan_ff == PAN_JUMP) begin
               if (!mode_ff) begin
                  act_vld_in = 1'b1;
                  if (back) begin
                     act_code_in = two_ff ? ACT_BACK_MEDIUM : ACT_BACK_SHORT;
                  end else begin
                     act_code_in = two_ff ? ACT_FWD_MEDIUM : ACT_FWD_SHORT;
                  end
               end else if (two_ff) begin
                  act_vld_in  = 1'b1;
                  act_code_in = back ? ACT_BACK_SHORT : ACT_FWD_SHORT;
               end
            end
            pan_in     = PAN_UNDEF;
            seen_in    = 1'b1;
            start_x_in = '1;
            start_y_in = '1;
            two_in     = 1'b0;
         end
         EV_PAN: begin
            seen_in    = 1'b1;
            handled_in = 1'b1;
            start_x_in = pan_sx;
            start_y_in = pan_sy;
            two_in     = pan_two;
            pan_in     = pan_new;
            if (pan_new == PAN_VOLUME) begin
               if (off > step_s) begin
                  act_vld_in  = 1'b1;
                  act_code_in = ACT_VOL_UP;
                  last_y_in   = s_y_ff;
               end else if (off < -step_s) begin
                  act_vld_in  = 1'b1;
                  act_code_in = ACT_VOL_DOWN;
                  last_y_in   = s_y_ff;
               end
            end
         end
         EV_TAP: begin
            seen_in     = 1'b1;
            handled_in  = 1'b1;
            act_vld_in  = 1'b1;
            act_code_in = ACT_PLAY_PAUSE;
         end
         EV_ZOOM: begin
            seen_in    = 1'b1;
            handled_in = 1'b1;
            if (!mode_ff) begin
               if (s_flags_ff == FlagBegin) begin
                  zoom_start_in = s_arg_ff;
               end else if (s_flags_ff == FlagEnd) begin
                  act_vld_in  = 1'b1;
                  act_code_in = (s_arg_ff > zoom_start_ff) ? ACT_FULLSCREEN : ACT_LEAVE_FULL;
               end
            end else if (s_flags_ff == FlagBegin) begin
               zoom_start_in = s_arg_ff;
               zl101_in      = s_arg101_ff;
               zl99_in       = s_arg99_ff;
            end else if (s_arg100_ff > zl101_ff) begin
               act_vld_in  = 1'b1;
               act_code_in = ACT_FOV_IN;
               zl101_in    = s_arg101_ff;
               zl99_in     = s_arg99_ff;
            end else if (s_arg100_ff < zl99_ff) begin
               act_vld_in  = 1'b1;
               act_code_in = ACT_FOV_OUT;
               zl101_in    = s_arg101_ff;
               zl99_in     = s_arg99_ff;
            end
         end
         EV_SCROLL: begin
            handled_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         classify_ff   <= ClassifyReset;
         step_ff       <= VolumeReset;
         s_vld_ff      <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         start_x_ff    <= '1;
         start_y_ff    <= '1;
         last_y_ff     <= '1;
         two_ff        <= 1'b0;
         pan_ff        <= PAN_UNDEF;
         seen_ff       <= 1'b0;
         zoom_start_ff <= '0;
         zl101_ff      <= '0;
         zl99_ff       <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_PROJECTED_MODE:    mode_ff     <= csr_wdata[0];
               CSR_CLASSIFY_DISTANCE: classify_ff <= csr_wdata;
               CSR_VOLUME_STEP:       step_ff     <= csr_wdata[StepWidth-1:0];
               default: begin
               end
            endcase
         end
         if (req_if.ready) begin
            s_vld_ff <= req_if.valid;
         end
         if (advance) begin
            rsp_vld_ff    <= 1'b1;
            start_x_ff    <= start_x_in;
            start_y_ff    <= start_y_in;
            last_y_ff     <= last_y_in;
            two_ff        <= two_in;
            pan_ff        <= pan_in;
            seen_ff       <= seen_in;
            zoom_start_ff <= zoom_start_in;
            zl101_ff      <= zl101_in;
            zl99_ff       <= zl99_in;
         end else if (rsp_if.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s_type_ff   <= req_if.req_type;
         s_flags_ff  <= req_if.gesture_flags;
         s_x_ff      <= req_if.pos_x;
         s_y_ff      <= req_if.pos_y;
         s_arg_ff    <= req_if.gesture_arg;
         s_arg100_ff <= ProdWidth'(req_if.gesture_arg) * ProdWidth'(100);
         s_arg101_ff <= ProdWidth'(req_if.gesture_arg) * ProdWidth'(101);
         s_arg99_ff  <= ProdWidth'(req_if.gesture_arg) * ProdWidth'(99);
      end
      if (advance) begin
         handled_ff  <= handled_in;
         act_vld_ff  <= act_vld_in;
         act_code_ff <= act_vld_in ? act_code_in : ACT_BACK_SHORT;
      end
   end

endmodule
